[design/utf8cpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cpd_pkg
// Shared types, constants and the byte classifier of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8cpd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 16;

    // Lead byte masks and match patterns
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'he0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2   = 8'hc0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'hf0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3   = 8'he0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'hf8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4   = 8'hf0;

    localparam logic [CNT_W-1:0]  CAP_RESET   = 16'hffff;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_SKIP,
        CLS_TERM
    } t_byte_class;

    typedef enum logic {
        ST_RUN,
        ST_REPLAY
    } t_back_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_byte_class       cls;
    } t_q_entry;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_push;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    // Sort a byte into its lead class
    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class c;
        priority if (b == '0) begin
            c = CLS_TERM;
        end else if (b < ASCII_LIMIT) begin
            c = CLS_ASCII;
        end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            c = CLS_LEAD2;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            c = CLS_LEAD3;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_SKIP;
        end
        return c;
    endfunction

endpackage

[design/utf8cpd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cpd_if
// Valid/ready channels of the UTF-8 decoder: byte input, result output and
// the capacity register write.
// ----------------------------------------------------------------------------
interface utf8cpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8cpd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        is_end;
    logic [15:0] char_count;

    modport source (output valid, output code_point, output is_end, output char_count,
                    input ready);
    modport sink   (input valid, input code_point, input is_end, input char_count,
                    output ready);
endinterface

interface utf8cpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink   (input valid, input out_capacity, output ready);
endinterface

[design/utf8cpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cpd_front
// Accepts input bytes, classifies each one and pushes it into the queue.
// ----------------------------------------------------------------------------
module utf8cpd_front
    import utf8cpd_pkg::*;
(
    utf8cpd_in_if.sink i_in,
    input  logic       i_q_full,
    output t_q_push    o_push
);

    // Take a beat whenever the queue has room
    assign i_in.ready = !i_q_full;

    // Tag the byte with its class on the way in
    always_comb begin
        o_push.valid      = i_in.valid && !i_q_full;
        o_push.entry.data = i_in.in_byte;
        o_push.entry.cls  = classify(i_in.in_byte);
    end

endmodule

[design/utf8cpd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cpd_queue
// Small FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module utf8cpd_queue
    import utf8cpd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

[design/utf8cpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8cpd_back
// Sequence assembly: holds open sequences, packs code points, replays the
// bytes after a dropped lead at the terminator and drives the result beat.
// ----------------------------------------------------------------------------
module utf8cpd_back
    import utf8cpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_head             i_head,
    output logic                o_pop,
    input  logic [CNT_W-1:0]    i_capacity,
    utf8cpd_out_if.source       o_out
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [BYTE_W-1:0]  r_held [3];
    logic [BYTE_W-1:0]  n_held [3];
    logic [1:0]         r_held_cnt;
    logic [1:0]         n_held_cnt;
    logic [1:0]         r_need;
    logic [1:0]         n_need;
    logic [CNT_W-1:0]   r_written;
    logic [CNT_W-1:0]   n_written;
    logic [BYTE_W-1:0]  r_tail [2];
    logic [BYTE_W-1:0]  n_tail [2];
    logic [1:0]         r_tail_cnt;
    logic [1:0]         n_tail_cnt;
    logic [1:0]         r_tail_idx;
    logic [1:0]         n_tail_idx;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [CP_W-1:0]    r_out_cp;
    logic [CP_W-1:0]    n_out_cp;
    logic               r_out_end;
    logic               n_out_end;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [CNT_W-1:0]   n_out_cnt;

    logic               stall;
    logic               feed_en;
    logic [BYTE_W-1:0]  feed_data;
    t_byte_class        feed_cls;
    logic               reload;
    logic               finish;
    logic               emit;
    logic [CP_W-1:0]    emit_cp;
    logic               emit_end;
    logic [CNT_W-1:0]   emit_cnt;
    logic               cap_full;
    logic [BYTE_W-1:0]  lead;

    assign stall    = r_out_valid && !o_out.ready;
    assign cap_full = ({1'b0, r_written} + 17'd1) >= {1'b0, i_capacity};
    assign lead     = r_held[0];

    // Pick the action of this cycle, then apply it to the sequence state
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_held_cnt  = r_held_cnt;
        n_need      = r_need;
        n_written   = r_written;
        n_tail      = r_tail;
        n_tail_cnt  = r_tail_cnt;
        n_tail_idx  = r_tail_idx;
        n_out_valid = r_out_valid;
        n_out_cp    = r_out_cp;
        n_out_end   = r_out_end;
        n_out_cnt   = r_out_cnt;
        o_pop       = 1'b0;
        feed_en     = 1'b0;
        feed_data   = i_head.entry.data;
        feed_cls    = i_head.entry.cls;
        reload      = 1'b0;
        finish      = 1'b0;
        emit        = 1'b0;
        emit_cp     = '0;
        emit_end    = 1'b0;
        emit_cnt    = '0;

        // Choose: take a queued byte, replay a held byte, drop an open lead or close the run
        if (!stall) begin
            unique case (r_state)
                ST_RUN: begin
                    if (i_head.valid) begin
                        o_pop = 1'b1;
                        if (i_head.entry.cls == CLS_TERM) begin
                            if (r_need == 2'd0) begin
                                finish = 1'b1;
                            end else begin
                                reload = 1'b1;
                            end
                        end else begin
                            feed_en = 1'b1;
                        end
                    end
                end
                ST_REPLAY: begin
                    if (r_tail_idx != r_tail_cnt) begin
                        feed_en    = 1'b1;
                        feed_data  = r_tail[r_tail_idx[0]];
                        feed_cls   = classify(r_tail[r_tail_idx[0]]);
                        n_tail_idx = r_tail_idx + 2'd1;
                    end else if (r_need != 2'd0) begin
                        reload = 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Feed one nonzero byte into the sequence assembler
        if (feed_en) begin
            if (r_need == 2'd0) begin
                if (!cap_full) begin
                    unique case (feed_cls)
                        CLS_ASCII: begin
                            emit    = 1'b1;
                            emit_cp = CP_W'(feed_data);
                        end
                        CLS_LEAD2: begin
                            n_need     = 2'd1;
                            n_held[0]  = feed_data;
                            n_held_cnt = 2'd1;
                        end
                        CLS_LEAD3: begin
                            n_need     = 2'd2;
                            n_held[0]  = feed_data;
                            n_held_cnt = 2'd1;
                        end
                        CLS_LEAD4: begin
                            n_need     = 2'd3;
                            n_held[0]  = feed_data;
                            n_held_cnt = 2'd1;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (r_held_cnt >= r_need) begin
                emit = 1'b1;
                unique case (r_need)
                    2'd1: emit_cp = {10'd0, lead[4:0], feed_data[5:0]};
                    2'd2: emit_cp = {5'd0, lead[3:0], r_held[1][5:0], feed_data[5:0]};
                    default: emit_cp = {lead[2:0], r_held[1][5:0], r_held[2][5:0],
                                        feed_data[5:0]};
                endcase
                n_need     = 2'd0;
                n_held_cnt = 2'd0;
            end else begin
                n_held[r_held_cnt] = feed_data;
                n_held_cnt         = r_held_cnt + 2'd1;
            end
            if (emit) begin
                n_written = r_written + 1'b1;
            end
        end

        // Drop the held lead and queue the bytes after it for replay
        if (reload) begin
            n_tail[0]  = r_held[1];
            n_tail[1]  = r_held[2];
            n_tail_cnt = r_held_cnt - 2'd1;
            n_tail_idx = 2'd0;
            n_need     = 2'd0;
            n_held_cnt = 2'd0;
            n_state    = ST_REPLAY;
        end

        // Close the run with the terminator beat
        if (finish) begin
            emit       = 1'b1;
            emit_end   = 1'b1;
            emit_cnt   = (i_capacity == '0) ? '0 : r_written + 1'b1;
            n_written  = '0;
            n_need     = 2'd0;
            n_held_cnt = 2'd0;
            n_state    = ST_RUN;
        end

        // Load the output register whenever it is free to move
        if (!stall) begin
            n_out_valid = emit;
            n_out_cp    = emit_cp;
            n_out_end   = emit_end;
            n_out_cnt   = emit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_held_cnt  <= '0;
            r_need      <= '0;
            r_written   <= '0;
            r_tail_cnt  <= '0;
            r_tail_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held_cnt  <= n_held_cnt;
            r_need      <= n_need;
            r_written   <= n_written;
            r_tail_cnt  <= n_tail_cnt;
            r_tail_idx  <= n_tail_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_held    <= n_held;
        r_tail    <= n_tail;
        r_out_cp  <= n_out_cp;
        r_out_end <= n_out_end;
        r_out_cnt <= n_out_cnt;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_cp;
    assign o_out.is_end     = r_out_end;
    assign o_out.char_count = r_out_cnt;

endmodule

[design/utf8_to_code_point_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_unit
// UTF-8 byte stream to code point decoder with capacity limit.
//
//   channel  dir  beat
//   i_in     in   in_byte: one byte of text, zero ends the string
//   o_out    out  code_point, is_end, char_count: one result
//   i_cfg    in   out_capacity: output buffer size, terminator included
//
// A nonzero byte is taken by the back stage from the queue head, so bytes
// stream at one per cycle while o_out does not stall and no replay runs;
// a byte is registered in the queue and its result in the output register.
// A terminator inside a sequence replays the bytes after each dropped lead.
// The queue (QUEUE_DEPTH entries) lets input run on while o_out stalls.
// Reset empties the queue and closes any sequence; capacity resets to 65535.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_unit
    import utf8cpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8cpd_in_if.sink    i_in,
    utf8cpd_out_if.source o_out,
    utf8cpd_cfg_if.sink   i_cfg
);

    logic [CNT_W-1:0] r_out_capacity;
    t_q_push          push;
    t_q_head          head;
    logic             q_full;
    logic             pop;

    // Capacity register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_out_capacity <= i_cfg.out_capacity;
        end
    end

    utf8cpd_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    utf8cpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    utf8cpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_capacity (r_out_capacity),
        .o_out      (o_out)
    );

endmodule

[verif/utf8_to_code_point_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_unit_test
// Drives zero-terminated byte strings into the decoder and keeps a running
// model of its sequence state, write count and capacity. The model predicts
// each code point and terminator result, and the results are checked in
// order, field by field. Directed strings cover every lead class, skipped
// bytes, unchecked continuations, strings cut short by the terminator and
// the capacity limit. Random strings follow, mostly well formed and some
// broken, under random capacities and random idling on both channels.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_unit_test;
    import utf8cpd_pkg::*;

    localparam int  SETTLE_CYCLES = 12;
    localparam int  IDLE_PCT      = 11;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             is_end;
        logic [CNT_W-1:0] char_count;
    } t_result;

    typedef logic [BYTE_W-1:0] t_byte_q [$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8cpd_in_if  in_ch ();
    utf8cpd_out_if out_ch ();
    utf8cpd_cfg_if cfg_ch ();

    utf8_to_code_point_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Decoder state as the model sees it
    logic [CNT_W-1:0]  capacity_now;
    logic [BYTE_W-1:0] seq_bytes [3];
    logic [1:0]        seq_held;
    logic [1:0]        seq_need;
    logic [CNT_W-1:0]  points_written;

    t_result due_results [$];
    int      mismatches = 0;
    int      bytes_sent = 0;
    bit      calm       = 1'b0;

    always #2 i_clk = ~i_clk;

    // Log one mismatch and count it
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Queue a code point result and bump the write count
    task automatic push_point(input logic [CP_W-1:0] cp);
        due_results.push_back('{code_point: cp, is_end: 1'b0, char_count: '0});
        points_written = points_written + 1'b1;
    endtask

    // Advance the model by one nonzero byte
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [CP_W-1:0] cp;
        if (seq_need == 2'd0) begin
            // no room left: a new ASCII byte or lead is ignored
            if ((17'(points_written) + 17'd1) >= 17'(capacity_now)) return;
            if (b < ASCII_LIMIT) begin
                push_point(CP_W'(b));
                return;
            end
            if ((b & MASK_LEAD2) == PAT_LEAD2) seq_need = 2'd1;
            else if ((b & MASK_LEAD3) == PAT_LEAD3) seq_need = 2'd2;
            else if ((b & MASK_LEAD4) == PAT_LEAD4) seq_need = 2'd3;
            else return;
            seq_bytes[0] = b;
            seq_held = 2'd1;
            return;
        end
        if (seq_held >= seq_need) begin
            // last byte of the sequence: pack the payload bits
            case (seq_need)
                2'd1: begin
                    cp = CP_W'({seq_bytes[0][4:0], b[5:0]});
                end
                2'd2: begin
                    cp = CP_W'({seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]});
                end
                default: begin
                    cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], b[5:0]};
                end
            endcase
            seq_need = 2'd0;
            seq_held = 2'd0;
            push_point(cp);
            return;
        end
        seq_bytes[seq_held] = b;
        seq_held = seq_held + 2'd1;
    endtask

    // Terminator: replay what followed an open lead, then close the string
    task automatic close_string();
        logic [BYTE_W-1:0] tail [2];
        int n;
        int i;
        logic [CNT_W-1:0] cnt;
        while (seq_need != 2'd0) begin
            n = 0;
            for (i = 1; i < seq_held; i++) begin
                tail[n] = seq_bytes[i];
                n++;
            end
            seq_need = 2'd0;
            seq_held = 2'd0;
            for (i = 0; i < n; i++) decode_byte(tail[i]);
        end
        cnt = (capacity_now == '0) ? '0 : points_written + 1'b1;
        due_results.push_back('{code_point: '0, is_end: 1'b1, char_count: cnt});
        points_written = '0;
        seq_held = 2'd0;
        seq_need = 2'd0;
    endtask

    // Send one byte beat, idling first at random; predict on acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (b == '0) close_string();
        else decode_byte(b);
    endtask

    task automatic send_text(input t_byte_q s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    // Hold the input and wait for every predicted result to drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the capacity register once the block is idle
    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        settle();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.out_capacity <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        capacity_now = cap;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd1;
        if (r == 1) return 16'hffff;
        if (r < 6) return CNT_W'($urandom_range(12, 2));
        return CNT_W'($urandom_range(65535, 13));
    endfunction

    task automatic send_cont();
        send_byte(8'h80 | 8'($urandom_range(63)));
    endtask

    // Mostly well-formed sequences with random payload, some noise and cut strings
    task automatic send_random_string(input int max_points);
        int n_points;
        int kind;
        int k;
        n_points = $urandom_range(max_points, 0);
        for (k = 0; k < n_points; k++) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                send_byte(8'($urandom_range(127, 1)));
            end else if (kind < 50) begin
                send_byte(8'hc0 | 8'($urandom_range(31)));
                send_cont();
            end else if (kind < 66) begin
                send_byte(8'he0 | 8'($urandom_range(15)));
                repeat (2) send_cont();
            end else if (kind < 80) begin
                send_byte(8'hf0 | 8'($urandom_range(7)));
                repeat (3) send_cont();
            end else if (kind < 92) begin
                send_byte(8'($urandom_range(255, 1)));
            end else begin
                // open a long lead and end the string early
                send_byte(8'he0 | 8'($urandom_range(23)));
                repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255, 1)));
                break;
            end
        end
        send_byte(8'h00);
    endtask

    task automatic test_lead_classes();
        write_capacity(16'hffff);
        send_text('{8'h01, 8'h7f,
                    8'hc2, 8'ha9,
                    8'hdf, 8'hbf,
                    8'he2, 8'h82, 8'hac,
                    8'hf0, 8'h9f, 8'h98, 8'h80,
                    8'hf7, 8'hbf, 8'hbf, 8'hbf,
                    8'h80, 8'hff, 8'hf8,
                    8'hc3, 8'h41,
                    8'h00});
    endtask

    task automatic test_cut_sequences();
        // two code points come out of the replay
        send_text('{8'hf0, 8'h41, 8'h42, 8'h00});
        // replayed byte opens a new lead that is dropped in turn
        send_text('{8'he2, 8'hc3, 8'h00});
        // empty string
        send_text('{8'h00});
    endtask

    task automatic test_capacity_limits();
        // smallest buffer: only the terminator fits
        write_capacity(16'd1);
        send_text('{8'h41, 8'hc3, 8'ha9, 8'h00});
        // one slot: the sequence fits, the byte after it is dropped
        write_capacity(16'd2);
        send_text('{8'hc3, 8'ha9, 8'h41, 8'h00});
        // capacity check applies during the replay too
        send_text('{8'hf0, 8'h41, 8'h42, 8'h00});
        write_capacity(16'd3);
        send_text('{8'h41, 8'he2, 8'h82, 8'hac, 8'h42, 8'h00});
        write_capacity(16'hffff);
        send_text('{8'h41, 8'h42, 8'h43, 8'h00});
    endtask

    task automatic test_random_text();
        int stop_at;
        stop_at = bytes_sent + 260;
        while (bytes_sent < stop_at) begin
            write_capacity(pick_capacity());
            repeat ($urandom_range(3, 1)) send_random_string(8);
        end
    endtask

    task automatic test_burst_no_idle();
        int stop_at;
        stop_at = bytes_sent + 60;
        write_capacity(pick_capacity());
        calm = 1'b1;
        while (bytes_sent < stop_at) send_random_string(8);
        settle();
        calm = 1'b0;
    endtask

    // Check each result beat against the oldest prediction; stall at random
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{code_point: out_ch.code_point, is_end: out_ch.is_end,
                    char_count: out_ch.char_count};
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%h end=%b cnt=%0d",
                                          got.code_point, got.is_end, got.char_count));
            end else begin
                want = due_results.pop_front();
                if (got.code_point !== want.code_point)
                    report_mismatch($sformatf("code_point got %h want %h",
                                              got.code_point, want.code_point));
                if (got.is_end !== want.is_end)
                    report_mismatch($sformatf("is_end got %b want %b",
                                              got.is_end, want.is_end));
                if (got.char_count !== want.char_count)
                    report_mismatch($sformatf("char_count got %0d want %0d",
                                              got.char_count, want.char_count));
            end
        end
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.out_capacity = '0;
        capacity_now        = CAP_RESET;
        seq_bytes           = '{default: '0};
        seq_held            = 2'd0;
        seq_need            = 2'd0;
        points_written      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lead_classes();
        test_cut_sequences();
        test_capacity_limits();
        test_random_text();
        test_burst_no_idle();

        settle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
